// ===== design/s16x8_pkg.sv =====
package s16x8_pkg;

  localparam int unsigned LANES  = 8;
  localparam int unsigned LANE_W = 16;
  localparam int unsigned VEC_W  = LANES * LANE_W;
  localparam int unsigned CNT_W  = 4;

  localparam logic [LANE_W-1:0] LANE_MAX  = 16'h7fff;
  localparam logic [LANE_W-1:0] LANE_MIN  = 16'h8000;
  localparam logic [LANE_W-1:0] LANE_ONES = 16'hffff;

  typedef enum logic [4:0] {
    OP_SPLAT  = 5'd0,
    OP_NEG    = 5'd1,
    OP_NOT    = 5'd2,
    OP_ADD    = 5'd3,
    OP_SUB    = 5'd4,
    OP_MUL    = 5'd5,
    OP_AND    = 5'd6,
    OP_OR     = 5'd7,
    OP_XOR    = 5'd8,
    OP_ADDSAT = 5'd9,
    OP_SUBSAT = 5'd10,
    OP_MIN    = 5'd11,
    OP_MAX    = 5'd12,
    OP_LT     = 5'd13,
    OP_LE     = 5'd14,
    OP_EQ     = 5'd15,
    OP_NE     = 5'd16,
    OP_GT     = 5'd17,
    OP_GE     = 5'd18,
    OP_SHL    = 5'd19,
    OP_SAR    = 5'd20
  } op_t;

  // Per-lane arithmetic results, registered between compute and select.
  typedef struct packed {
    logic [LANE_W-1:0] neg;
    logic [LANE_W-1:0] prod;
    logic [LANE_W:0]   sum;
    logic [LANE_W:0]   diff;
    logic              lt;
    logic              eq;
    logic [LANE_W-1:0] shl;
    logic [LANE_W-1:0] sar;
  } lane_raw_t;

  // Clamp a 17-bit signed value to the 16-bit signed range.
  function automatic logic [LANE_W-1:0] sat17(input logic [LANE_W:0] v);
    logic [LANE_W-1:0] r;
    if (v[LANE_W] != v[LANE_W-1]) begin
      r = v[LANE_W] ? LANE_MIN : LANE_MAX;
    end else begin
      r = v[LANE_W-1:0];
    end
    return r;
  endfunction

  function automatic logic [LANE_W-1:0] lane_select(
    input op_t               op,
    input logic [LANE_W-1:0] a,
    input logic [LANE_W-1:0] b,
    input logic [LANE_W-1:0] scalar,
    input lane_raw_t         raw
  );
    logic [LANE_W-1:0] r;
    logic              gt;
    gt = !raw.lt && !raw.eq;
    unique case (op)
      OP_SPLAT:  r = scalar;
      OP_NEG:    r = raw.neg;
      OP_NOT:    r = ~a;
      OP_ADD:    r = raw.sum[LANE_W-1:0];
      OP_SUB:    r = raw.diff[LANE_W-1:0];
      OP_MUL:    r = raw.prod;
      OP_AND:    r = a & b;
      OP_OR:     r = a | b;
      OP_XOR:    r = a ^ b;
      OP_ADDSAT: r = sat17(raw.sum);
      OP_SUBSAT: r = sat17(raw.diff);
      OP_MIN:    r = raw.lt ? a : b;
      OP_MAX:    r = gt ? a : b;
      OP_LT:     r = raw.lt ? LANE_ONES : '0;
      OP_LE:     r = (raw.lt || raw.eq) ? LANE_ONES : '0;
      OP_EQ:     r = raw.eq ? LANE_ONES : '0;
      OP_NE:     r = raw.eq ? '0 : LANE_ONES;
      OP_GT:     r = gt ? LANE_ONES : '0;
      OP_GE:     r = raw.lt ? '0 : LANE_ONES;
      OP_SHL:    r = raw.shl;
      OP_SAR:    r = raw.sar;
      default:   r = '0;
    endcase
    return r;
  endfunction

endpackage

// ===== design/simd_int16x8_alu_unit.sv =====
// Eight-lane signed 16-bit vector ALU. A request carries the opcode in s_tuser
// and both 128-bit operands, the splat scalar and the shift count in s_tdata;
// each request answers with exactly one 128-bit result on m_tdata. Lanes are
// independent and no state carries over between requests. The datapath is a
// three-stage pipeline (operand register, per-lane arithmetic register, output
// register), so a new request is taken every cycle while the output side is
// ready. A result passes through the three registers in that order and leaves
// on m_tdata when the output side is ready. Each stage holds its item under
// backpressure and fills any bubble ahead of it, so the block keeps accepting
// while a finished result waits, until all three stages are full.
// Wrapping ops keep the low 16 bits, saturating ops clamp to -32768..32767,
// compares give all-ones or zero lanes, shifts use count bits 3:0 only, and
// an unknown opcode yields a zero result.
module simd_int16x8_alu_unit (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // [63:0] a_lanes_low, [127:64] a_lanes_high, [191:128] b_lanes_low,
  // [255:192] b_lanes_high, [271:256] splat_scalar, [303:272] shift_count
  input  logic [303:0] s_tdata,
  // [4:0] req_type
  input  logic [4:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // [63:0] result_lanes_low, [127:64] result_lanes_high
  output logic [127:0] m_tdata
);
  import s16x8_pkg::*;

  // Stage enables: a stage loads when empty or when its item moves on.
  logic en1, en2, en3;
  logic v1, v2, v3;

  // Stage 1: operands
  op_t               op1;
  logic [VEC_W-1:0]  a1, b1;
  logic [LANE_W-1:0] scalar1;
  logic [CNT_W-1:0]  cnt1;

  // Stage 2: per-lane arithmetic, operands carried along for selection
  op_t               op2;
  logic [VEC_W-1:0]  a2, b2;
  logic [LANE_W-1:0] scalar2;
  lane_raw_t         raw2 [LANES];

  logic [VEC_W-1:0]  result_next;

  assign en3      = !v3 || m_tready;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign s_tready = en1;
  assign m_tvalid = v3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (en1) v1 <= s_tvalid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      op1     <= op_t'(s_tuser[4:0]);
      a1      <= s_tdata[127:0];
      b1      <= s_tdata[255:128];
      scalar1 <= s_tdata[271:256];
      cnt1    <= s_tdata[275:272];
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      op2     <= op1;
      a2      <= a1;
      b2      <= b1;
      scalar2 <= scalar1;
    end
  end

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    s16x8_lane u_lane (
      .clk (clk),
      .en  (en2),
      .a   (a1[i*LANE_W +: LANE_W]),
      .b   (b1[i*LANE_W +: LANE_W]),
      .cnt (cnt1),
      .raw (raw2[i])
    );

    assign result_next[i*LANE_W +: LANE_W] =
      lane_select(op2, a2[i*LANE_W +: LANE_W], b2[i*LANE_W +: LANE_W],
                  scalar2, raw2[i]);
  end

  // Stage 3: output register
  always_ff @(posedge clk) begin
    if (en3) begin
      m_tdata <= result_next;
    end
  end

`ifndef SYNTHESIS
  // Reset empties every stage.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!v1 && !v2 && !v3))
    else $error("pipeline not empty after reset");

  // With all stages full and the output stalled, no new request may enter.
  a_full_backpressure: assert property (@(posedge clk) disable iff (rst)
    (v1 && v2 && v3 && !m_tready) |-> !s_tready)
    else $error("request accepted into a full pipeline");

  // A stalled middle stage keeps its item.
  a_mid_hold: assert property (@(posedge clk) disable iff (rst)
    (v2 && !en3) |=> (v2 && $stable(op2) && $stable(a2)))
    else $error("middle stage lost its item under stall");

  // A stalled first stage keeps its item.
  a_first_hold: assert property (@(posedge clk) disable iff (rst)
    (v1 && !en2) |=> (v1 && $stable(op1) && $stable(b1)))
    else $error("first stage lost its item under stall");
`endif

endmodule

// ===== design/s16x8_lane.sv =====
module s16x8_lane (
  input  logic                                clk,
  input  logic                                en,
  input  logic [s16x8_pkg::LANE_W-1:0]        a,
  input  logic [s16x8_pkg::LANE_W-1:0]        b,
  input  logic [s16x8_pkg::CNT_W-1:0]         cnt,
  output s16x8_pkg::lane_raw_t                raw
);
  import s16x8_pkg::*;

  lane_raw_t         raw_next;
  logic [2*LANE_W-1:0] prod_full;

  always_comb begin
    prod_full     = a * b;
    raw_next.neg  = LANE_W'(0) - a;
    raw_next.prod = prod_full[LANE_W-1:0];
    raw_next.sum  = {a[LANE_W-1], a} + {b[LANE_W-1], b};
    raw_next.diff = {a[LANE_W-1], a} - {b[LANE_W-1], b};
    raw_next.lt   = $signed(a) < $signed(b);
    raw_next.eq   = (a == b);
    raw_next.shl  = a << cnt;
    raw_next.sar  = LANE_W'($signed(a) >>> cnt);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      raw <= raw_next;
    end
  end

endmodule

// ===== sim/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import s16x8_pkg::*;

  // Idle cycles with no handshake on either side before the run is abandoned.
  localparam int IDLE_LIMIT = 2000;
  localparam int REPORT_MAX = 10;

  // Edge operand lanes: max, min, zero, -1, min+1, max-1, -2, 1 against partners
  // chosen so that both saturating ops clip both ways and compares hit equal.
  localparam logic [63:0] EDGE_A_LO = 64'hffff_0000_8000_7fff;
  localparam logic [63:0] EDGE_A_HI = 64'h0001_fffe_7ffe_8001;
  localparam logic [63:0] EDGE_B_LO = 64'h7fff_8000_8000_7fff;
  localparam logic [63:0] EDGE_B_HI = 64'h0002_fffe_8000_7fff;

  typedef struct {
    op_t                op;
    logic [63:0]        a_lo;
    logic [63:0]        a_hi;
    logic [63:0]        b_lo;
    logic [63:0]        b_hi;
    logic signed [15:0] scalar;
    logic signed [31:0] count;
  } alu_req_t;

  typedef struct {
    logic [63:0] lo;
    logic [63:0] hi;
  } lanes_result_t;

  // Holds the predicted result vectors in request order and compares them with
  // what comes out of the block.
  class vec_alu_scoreboard;
    lanes_result_t expected_results[$];
    int            failures;
    int            reported;

    function new();
      failures = 0;
      reported = 0;
    endfunction

    function logic [15:0] clamp_lane(int v);
      if (v > 32767) return LANE_MAX;
      if (v < -32768) return LANE_MIN;
      return v[15:0];
    endfunction

    function logic [15:0] lane_value(op_t op, logic [15:0] a, logic [15:0] b,
                                     logic [15:0] scalar, logic [3:0] cnt);
      int          sa;
      int          sb;
      logic [15:0] r;
      sa = int'($signed(a));
      sb = int'($signed(b));
      case (op)
        OP_SPLAT:  r = scalar;
        OP_NEG:    r = -a;
        OP_NOT:    r = ~a;
        OP_ADD:    r = a + b;
        OP_SUB:    r = a - b;
        OP_MUL:    r = a * b;
        OP_AND:    r = a & b;
        OP_OR:     r = a | b;
        OP_XOR:    r = a ^ b;
        OP_ADDSAT: r = clamp_lane(sa + sb);
        OP_SUBSAT: r = clamp_lane(sa - sb);
        OP_MIN:    r = (sa < sb) ? a : b;
        OP_MAX:    r = (sa > sb) ? a : b;
        OP_LT:     r = (sa < sb) ? LANE_ONES : '0;
        OP_LE:     r = (sa <= sb) ? LANE_ONES : '0;
        OP_EQ:     r = (a == b) ? LANE_ONES : '0;
        OP_NE:     r = (a != b) ? LANE_ONES : '0;
        OP_GT:     r = (sa > sb) ? LANE_ONES : '0;
        OP_GE:     r = (sa >= sb) ? LANE_ONES : '0;
        OP_SHL:    r = a << cnt;
        OP_SAR:    r = $signed(a) >>> cnt;
        default:   r = '0;
      endcase
      return r;
    endfunction

    function void note_request(alu_req_t req);
      logic [127:0]  va;
      logic [127:0]  vb;
      logic [127:0]  vr;
      lanes_result_t res;
      va = {req.a_hi, req.a_lo};
      vb = {req.b_hi, req.b_lo};
      for (int i = 0; i < LANES; i++) begin
        vr[16*i +: 16] = lane_value(req.op, va[16*i +: 16], vb[16*i +: 16],
                                    req.scalar, req.count[3:0]);
      end
      res.lo = vr[63:0];
      res.hi = vr[127:64];
      expected_results.push_back(res);
    endfunction

    function void check_result(logic [127:0] data);
      lanes_result_t want;
      if (expected_results.size() == 0) begin
        failures++;
        if (reported < REPORT_MAX) begin
          reported++;
          $display("%0t: result %h arrived with no request outstanding", $realtime, data);
        end
        return;
      end
      want = expected_results.pop_front();
      if (data[63:0] !== want.lo || data[127:64] !== want.hi) begin
        failures++;
        if (reported < REPORT_MAX) begin
          reported++;
          if (data[63:0] !== want.lo)
            $display("%0t: result_lanes_low expected %h got %h",
                     $realtime, want.lo, data[63:0]);
          if (data[127:64] !== want.hi)
            $display("%0t: result_lanes_high expected %h got %h",
                     $realtime, want.hi, data[127:64]);
        end
      end
    endfunction
  endclass

  logic         clk;
  logic         rst      = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [303:0] s_tdata  = '0;
  logic [4:0]   s_tuser  = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [127:0] m_tdata;

  vec_alu_scoreboard board = new();
  bit                quiet_phase = 1'b0;
  int                idle_cycles = 0;

  simd_int16x8_alu_unit u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Mostly no gap, some short ones, a few long; none in quiet phases.
  function automatic int pick_gap();
    int r;
    if (quiet_phase) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Lanes lean toward the signed extremes and their neighbors.
  function automatic logic [15:0] pick_lane();
    case ($urandom_range(0, 9))
      0: return LANE_MAX;
      1: return LANE_MIN;
      2: return 16'h0000;
      3: return 16'hffff;
      4: return 16'(LANE_MIN + 16'd1);
      5: return 16'(LANE_MAX - 16'd1);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic alu_req_t random_request();
    alu_req_t     req;
    logic [127:0] va;
    logic [127:0] vb;
    for (int i = 0; i < LANES; i++) begin
      va[16*i +: 16] = pick_lane();
      // Equal lanes now and then so eq/ne/le/ge see their boundary.
      vb[16*i +: 16] = ($urandom_range(0, 3) == 0) ? va[16*i +: 16] : pick_lane();
    end
    req.op     = op_t'($urandom_range(OP_SPLAT, OP_SAR));
    req.a_lo   = va[63:0];
    req.a_hi   = va[127:64];
    req.b_lo   = vb[63:0];
    req.b_hi   = vb[127:64];
    req.scalar = 16'($urandom);
    req.count  = $urandom;
    return req;
  endfunction

  // Drive one request from a rising edge and hold it until accepted. The
  // handshake is judged at the falling edge, when inputs and outputs are settled.
  task automatic issue_request(alu_req_t req);
    int gap;
    bit taken;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= req.op;
    // [63:0] a low, [127:64] a high, [191:128] b low, [255:192] b high,
    // [271:256] scalar, [303:272] shift count
    s_tdata  <= {req.count, req.scalar, req.b_hi, req.b_lo, req.a_hi, req.a_lo};
    do begin
      @(negedge clk);
      taken = s_tready;
      if (taken) board.note_request(req);
      @(posedge clk);
    end while (!taken);
  endtask

  // Output side: random stalls between ready stretches, held high when quiet.
  initial begin
    int stall;
    forever begin
      stall = pick_gap();
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
  end

  always @(negedge clk) begin
    if (!rst && m_tvalid && m_tready) board.check_result(m_tdata);
  end

  // Watchdog on progress: any handshake clears it.
  always @(negedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    alu_req_t req;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed: every opcode on the edge lanes, then splat and shift corners.
    req.a_lo = EDGE_A_LO;
    req.a_hi = EDGE_A_HI;
    req.b_lo = EDGE_B_LO;
    req.b_hi = EDGE_B_HI;
    for (int k = OP_SPLAT; k <= OP_SAR; k++) begin
      req.op     = op_t'(k);
      req.scalar = (req.op == OP_SPLAT) ? LANE_MIN : 16'($urandom);
      // Negative count with low bits 1: only bits 3:0 may matter.
      req.count  = 32'hffff_fff1;
      issue_request(req);
    end
    req.op     = OP_SPLAT;
    req.scalar = LANE_MAX;
    issue_request(req);
    req.op     = OP_SHL;
    req.count  = 32'sd15;
    issue_request(req);
    req.op     = OP_SAR;
    issue_request(req);
    // Count of 16 with the sign bit set wraps to a zero shift.
    req.count  = 32'h8000_0010;
    issue_request(req);

    // Random phases; every fourth runs with no idling on either side.
    for (int phase = 0; phase < 9; phase++) begin
      quiet_phase = (phase % 4 == 3);
      repeat (150) issue_request(random_request());
    end
    quiet_phase = 1'b0;
    s_tvalid <= 1'b0;

    while (board.expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (board.failures == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== simd_int16x8_alu_unit.f =====
design/s16x8_pkg.sv
design/s16x8_lane.sv
design/simd_int16x8_alu_unit.sv
sim/testbench.sv
